// File: design/viterbi_decoder_k5_erasures_defines.svh
// ----------------------------------------------------------------------------
// Viterbi decoder assertion macros
// Shared property forms for the checkers of the decoder.
// ----------------------------------------------------------------------------
`ifndef VITERBI_DECODER_K5_ERASURES_DEFINES_SVH
`define VITERBI_DECODER_K5_ERASURES_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define VDK5_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define VDK5_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/vdk5_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Viterbi decoder package
// Types, constants and code functions of the K=5 rate-1/4 decoder.
// ----------------------------------------------------------------------------
package vdk5_pkg;

   localparam int NUM_STATES    = 16;
   localparam int STATE_W       = 4;
   localparam int METRIC_W      = 12;
   localparam int BYTE_W        = 8;
   localparam int CNT_W         = 4;
   localparam int MAX_STEPS_DEF = 512;

   localparam logic [METRIC_W-1:0] METRIC_MAX = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACS,
      ST_COMMIT,
      ST_TRACE
   } dec_state_type;

   typedef enum logic [2:0] {
      TB_IDLE,
      TB_BACK,
      TB_FETCH,
      TB_PACK,
      TB_SEND
   } tb_state_type;

   typedef struct packed {
      logic dec_we;
      logic start;
   } tb_cmd_type;

   function automatic logic [3:0] code_word(input logic [STATE_W-1:0] p, input logic u);
      logic [3:0] cw;
      cw[0] = u ^ p[0] ^ p[3];
      cw[1] = u ^ p[1] ^ p[2] ^ p[3];
      cw[2] = u ^ p[0] ^ p[1] ^ p[3];
      cw[3] = u ^ p[0] ^ p[2] ^ p[3];
      return cw;
   endfunction

   function automatic logic [2:0] branch_cost(input logic [3:0] cw, input logic [3:0] rx,
                                              input logic [3:0] er);
      logic [3:0] diff;
      diff = (cw ^ rx) & ~er;
      return 3'(diff[0]) + 3'(diff[1]) + 3'(diff[2]) + 3'(diff[3]);
   endfunction

endpackage

// File: design/vdk5_acs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Viterbi decoder add-compare-select unit
// Branch cost, add, compare and select for one trellis state.
// ----------------------------------------------------------------------------
module vdk5_acs
   import vdk5_pkg::*;
(
   input  logic [STATE_W-2:0]  pred_lo,
   input  logic                in_bit,
   input  logic [3:0]          rx,
   input  logic [3:0]          er,
   input  logic [METRIC_W-1:0] metric_lo,
   input  logic [METRIC_W-1:0] metric_hi,
   input  logic                reach_lo,
   input  logic                reach_hi,
   output logic [METRIC_W-1:0] metric_out,
   output logic                decision,
   output logic                reach_out
);

   localparam int SUM_W = METRIC_W + 1;

   logic [STATE_W-1:0] p0;
   logic [STATE_W-1:0] p1;
   logic [SUM_W-1:0]   sum_lo;
   logic [SUM_W-1:0]   sum_hi;
   logic [SUM_W-1:0]   sum_sel;
   logic               pick_hi;

   assign p0     = {1'b0, pred_lo};
   assign p1     = {1'b1, pred_lo};
   assign sum_lo = {1'b0, metric_lo} + SUM_W'(branch_cost(code_word(p0, in_bit), rx, er));
   assign sum_hi = {1'b0, metric_hi} + SUM_W'(branch_cost(code_word(p1, in_bit), rx, er));

   always_comb begin
      pick_hi = 1'b0;
      sum_sel = '0;
      if (reach_lo && reach_hi) begin
         pick_hi = (sum_hi < sum_lo);
         sum_sel = pick_hi ? sum_hi : sum_lo;
      end else if (reach_lo) begin
         sum_sel = sum_lo;
      end else if (reach_hi) begin
         pick_hi = 1'b1;
         sum_sel = sum_hi;
      end
   end

   assign metric_out = (sum_sel > {1'b0, METRIC_MAX}) ? METRIC_MAX : sum_sel[METRIC_W-1:0];
   assign decision   = pick_hi;
   assign reach_out  = reach_lo | reach_hi;

endmodule

// File: design/vdk5_traceback.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Viterbi decoder traceback
// Survivor store, traceback from state zero and packing into output chunks.
// ----------------------------------------------------------------------------
module vdk5_traceback
   import vdk5_pkg::*;
#(
   parameter int MAX_STEPS = MAX_STEPS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tb_cmd_type                       cmd,
   input  logic [$clog2(MAX_STEPS)-1:0]     wr_addr,
   input  logic [NUM_STATES-1:0]            wr_data,
   input  logic [$clog2(MAX_STEPS+1)-1:0]   steps,
   output logic                             done,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,
   output logic                             rsp_tlast
);

   localparam int AW = $clog2(MAX_STEPS);
   localparam int CW = $clog2(MAX_STEPS + 1);

   logic [NUM_STATES-1:0] dec_mem [MAX_STEPS];
   logic                  bit_mem [MAX_STEPS];

   tb_state_type          st_ff, st_in;
   logic [CW-1:0]         steps_ff, steps_in;
   logic [AW-1:0]         rd_addr_ff, rd_addr_in;
   logic                  issue_ff, issue_in;
   logic [AW-1:0]         addr_q_ff, addr_q_in;
   logic                  vld_q_ff, vld_q_in;
   logic [STATE_W-1:0]    trace_ff, trace_in;
   logic [CW-1:0]         pos_ff, pos_in;
   logic [BYTE_W-1:0]     byte_ff, byte_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  last_ff, last_in;
   logic [NUM_STATES-1:0] dec_q_ff;
   logic                  bit_q_ff;
   logic                  bit_we;
   logic [CW-1:0]         pos_next;

   always_ff @(posedge clock) begin
      if (cmd.dec_we) begin
         dec_mem[wr_addr] <= wr_data;
      end
      dec_q_ff <= dec_mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (bit_we) begin
         bit_mem[addr_q_ff] <= trace_ff[0];
      end
      bit_q_ff <= bit_mem[pos_ff[AW-1:0]];
   end

   assign pos_next = pos_ff + CW'(1);

   always_comb begin
      st_in      = st_ff;
      steps_in   = steps_ff;
      rd_addr_in = rd_addr_ff;
      issue_in   = issue_ff;
      addr_q_in  = addr_q_ff;
      vld_q_in   = vld_q_ff;
      trace_in   = trace_ff;
      pos_in     = pos_ff;
      byte_in    = byte_ff;
      cnt_in     = cnt_ff;
      last_in    = last_ff;
      bit_we     = 1'b0;
      done       = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (st_ff)
         TB_IDLE: begin
            if (cmd.start) begin
               steps_in   = steps;
               rd_addr_in = AW'(steps - CW'(1));
               issue_in   = 1'b1;
               vld_q_in   = 1'b0;
               trace_in   = '0;
               st_in      = TB_BACK;
            end
         end
         TB_BACK: begin
            vld_q_in  = issue_ff;
            addr_q_in = rd_addr_ff;
            if (issue_ff) begin
               if (rd_addr_ff == '0) begin
                  issue_in = 1'b0;
               end else begin
                  rd_addr_in = rd_addr_ff - AW'(1);
               end
            end
            if (vld_q_ff) begin
               bit_we   = 1'b1;
               trace_in = {dec_q_ff[trace_ff], trace_ff[STATE_W-1:1]};
               if (addr_q_ff == '0) begin
                  pos_in  = '0;
                  cnt_in  = '0;
                  byte_in = '0;
                  st_in   = TB_FETCH;
               end
            end
         end
         TB_FETCH: begin
            st_in = TB_PACK;
         end
         TB_PACK: begin
            byte_in[~cnt_ff[2:0]] = bit_q_ff;
            cnt_in  = cnt_ff + CNT_W'(1);
            pos_in  = pos_next;
            last_in = (pos_next == steps_ff);
            if ((cnt_ff == CNT_W'(BYTE_W - 1)) || (pos_next == steps_ff)) begin
               st_in = TB_SEND;
            end else begin
               st_in = TB_FETCH;
            end
         end
         TB_SEND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (last_ff) begin
                  done  = 1'b1;
                  st_in = TB_IDLE;
               end else begin
                  byte_in = '0;
                  cnt_in  = '0;
                  st_in   = TB_FETCH;
               end
            end
         end
         default: begin
            st_in = TB_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= TB_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff   <= steps_in;
      rd_addr_ff <= rd_addr_in;
      issue_ff   <= issue_in;
      addr_q_ff  <= addr_q_in;
      vld_q_ff   <= vld_q_in;
      trace_ff   <= trace_in;
      pos_ff     <= pos_in;
      byte_ff    <= byte_in;
      cnt_ff     <= cnt_in;
      last_ff    <= last_in;
   end

   assign rsp_tdata = {4'b0, cnt_ff, byte_ff};
   assign rsp_tlast = last_ff;

endmodule

// File: design/viterbi_decoder_k5_erasures.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Viterbi decoder, K=5, rate 1/4, with erasures
// Hard-decision decoder for the 16-state mother code, one trellis step per
// input transaction, decoded bits out as byte chunks after the final step.
// req channel: one transaction per trellis step. tdata[3:0] received bits,
// tdata[7:4] erasure mask, tlast marks the final step of a block.
// rsp channel: decoded chunks after the final step. tdata[7:0] decoded byte
// (earliest bit in bit 7), tdata[11:8] valid bit count, tlast on last chunk.
// After acceptance a step holds the block: the single add-compare-select
// unit visits the 16 states in turn, then a commit state stores metrics and
// the survivor word. req_tready is high only while the block waits, so a new
// step is not taken until the previous one has been committed.
// After the final step of an N-step block (tlast, or MAX_STEPS reached),
// traceback reads the survivor memory once per cycle, then each decoded bit
// passes through fetch and pack states on the bit memory port, and each chunk
// waits for its handshake. Reset clears the path metrics, leaves only state 0
// reachable and zeroes the step count; the survivor memory is not cleared.
// When rsp_tready is low the current chunk holds and decoding pauses; no
// new step is taken until the last chunk of the block has gone.
// ----------------------------------------------------------------------------
module viterbi_decoder_k5_erasures
   import vdk5_pkg::*;
#(
   parameter int MAX_STEPS = MAX_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] received_bits, [7:4] erased_mask
   input  logic        req_tlast,   // last_step
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] decoded_byte, [11:8] bit_count, [15:12] zero
   output logic        rsp_tlast    // last_chunk
);

   localparam int AW = $clog2(MAX_STEPS);
   localparam int CW = $clog2(MAX_STEPS + 1);

   dec_state_type         state_ff, state_in;
   logic [3:0]            rx_ff, rx_in;
   logic [3:0]            er_ff, er_in;
   logic                  last_ff, last_in;
   logic [STATE_W-1:0]    n_ff, n_in;
   logic [METRIC_W-1:0]   old_metric_ff [NUM_STATES];
   logic [METRIC_W-1:0]   old_metric_in [NUM_STATES];
   logic [METRIC_W-1:0]   new_metric_ff [NUM_STATES];
   logic [METRIC_W-1:0]   new_metric_in [NUM_STATES];
   logic [NUM_STATES-1:0] old_reach_ff, old_reach_in;
   logic [NUM_STATES-1:0] new_reach_ff, new_reach_in;
   logic [NUM_STATES-1:0] dec_ff, dec_in;
   logic [AW-1:0]         step_cnt_ff, step_cnt_in;
   logic [CW-1:0]         steps;
   logic                  end_block;
   logic [METRIC_W-1:0]   acs_metric;
   logic                  acs_dec;
   logic                  acs_reach;
   tb_cmd_type            tb_cmd;
   logic                  tb_done;

   assign steps     = CW'(step_cnt_ff) + CW'(1);
   assign end_block = last_ff || (steps == CW'(MAX_STEPS));

   vdk5_acs u_acs (
      .pred_lo    (n_ff[STATE_W-1:1]),
      .in_bit     (n_ff[0]),
      .rx         (rx_ff),
      .er         (er_ff),
      .metric_lo  (old_metric_ff[0]),
      .metric_hi  (old_metric_ff[NUM_STATES/2]),
      .reach_lo   (old_reach_ff[0]),
      .reach_hi   (old_reach_ff[NUM_STATES/2]),
      .metric_out (acs_metric),
      .decision   (acs_dec),
      .reach_out  (acs_reach)
   );

   vdk5_traceback #(
      .MAX_STEPS (MAX_STEPS)
   ) u_traceback (
      .clock      (clock),
      .reset      (reset),
      .cmd        (tb_cmd),
      .wr_addr    (step_cnt_ff),
      .wr_data    (dec_ff),
      .steps      (steps),
      .done       (tb_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always_comb begin
      state_in      = state_ff;
      rx_in         = rx_ff;
      er_in         = er_ff;
      last_in       = last_ff;
      n_in          = n_ff;
      old_metric_in = old_metric_ff;
      new_metric_in = new_metric_ff;
      old_reach_in  = old_reach_ff;
      new_reach_in  = new_reach_ff;
      dec_in        = dec_ff;
      step_cnt_in   = step_cnt_ff;
      req_tready    = 1'b0;
      tb_cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               rx_in    = req_tdata[3:0];
               er_in    = req_tdata[7:4];
               last_in  = req_tlast;
               n_in     = '0;
               state_in = ST_ACS;
            end
         end
         ST_ACS: begin
            for (int i = 0; i < NUM_STATES - 1; i++) begin
               new_metric_in[i] = new_metric_ff[i+1];
            end
            new_metric_in[NUM_STATES-1] = acs_metric;
            new_reach_in = {acs_reach, new_reach_ff[NUM_STATES-1:1]};
            dec_in       = {acs_dec, dec_ff[NUM_STATES-1:1]};
            // advance both predecessor halves after each butterfly
            if (n_ff[0]) begin
               for (int i = 0; i < NUM_STATES/2 - 1; i++) begin
                  old_metric_in[i]                = old_metric_ff[i+1];
                  old_metric_in[i+NUM_STATES/2]   = old_metric_ff[i+1+NUM_STATES/2];
               end
               old_reach_in = {old_reach_ff[NUM_STATES-1], old_reach_ff[NUM_STATES-1:9],
                               old_reach_ff[7], old_reach_ff[7:1]};
            end
            n_in = n_ff + STATE_W'(1);
            if (n_ff == STATE_W'(NUM_STATES - 1)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            tb_cmd.dec_we = 1'b1;
            if (end_block) begin
               tb_cmd.start = 1'b1;
               for (int i = 0; i < NUM_STATES; i++) begin
                  old_metric_in[i] = '0;
               end
               old_reach_in = NUM_STATES'(1);
               step_cnt_in  = '0;
               state_in     = ST_TRACE;
            end else begin
               old_metric_in = new_metric_ff;
               old_reach_in  = new_reach_ff;
               step_cnt_in   = steps[AW-1:0];
               state_in      = ST_IDLE;
            end
         end
         ST_TRACE: begin
            if (tb_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_cnt_ff  <= '0;
         old_reach_ff <= NUM_STATES'(1);
         for (int i = 0; i < NUM_STATES; i++) begin
            old_metric_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         step_cnt_ff   <= step_cnt_in;
         old_reach_ff  <= old_reach_in;
         old_metric_ff <= old_metric_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_ff         <= rx_in;
      er_ff         <= er_in;
      last_ff       <= last_in;
      n_ff          <= n_in;
      new_metric_ff <= new_metric_in;
      new_reach_ff  <= new_reach_in;
      dec_ff        <= dec_in;
   end

endmodule

// File: design/vdk5_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Viterbi decoder port checker
// Properties on the decoder's ports over time, bound to the top level.
// ----------------------------------------------------------------------------
`include "viterbi_decoder_k5_erasures_defines.svh"

module vdk5_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   `VDK5_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp transaction changed while stalled")
   `VDK5_ASSERT_SAME(a_no_overlap, rsp_tvalid, !req_tready, "step accepted while chunks pending")
   `VDK5_ASSERT_NEXT(a_step_busy, req_tvalid && req_tready, !req_tready, "ready again right after a step")
   `VDK5_ASSERT_SAME(a_count_range, rsp_tvalid, (rsp_tdata[11:8] != 4'd0) && (rsp_tdata[11:8] <= 4'd8), "bit count out of range")
   `VDK5_ASSERT_SAME(a_full_chunk, rsp_tvalid && !rsp_tlast, rsp_tdata[11:8] == 4'd8, "short chunk before last")

endmodule

bind viterbi_decoder_k5_erasures vdk5_checker u_vdk5_checker (.*);

// File: dv/vdk5_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Viterbi decoder stream checker
// Watches the req and rsp streams of the decoder. It runs its own trellis,
// one step per accepted req transaction, and traces back at the end of each
// block to predict the decoded chunks. Every accepted rsp transaction is
// compared field by field with the oldest predicted chunk.
// ----------------------------------------------------------------------------
module vdk5_decode_checker
   import vdk5_pkg::*;
#(
   parameter int MAX_STEPS = MAX_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] received_bits, [7:4] erased_mask
   input  logic        req_tlast,   // last_step
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [7:0] decoded_byte, [11:8] bit_count
   input  logic        rsp_tlast,   // last_chunk
   output int          mismatch_count,
   output int          chunks_pending,
   output int          chunks_checked
);

   // generator taps over {D^4, D^3, D^2, D, 1}
   localparam logic [4:0] GEN_TAPS [4] = '{5'b10011, 5'b11101, 5'b10111, 5'b11011};

   typedef struct packed {
      logic [BYTE_W-1:0] bits;
      logic [CNT_W-1:0]  count;
      logic              last;
   } chunk_type;

   chunk_type             chunk_queue[$];
   logic [METRIC_W-1:0]   metric[NUM_STATES];
   logic [NUM_STATES-1:0] reachable;
   logic [NUM_STATES-1:0] survivor[MAX_STEPS];
   int                    step_index;

   function automatic int path_cost(input logic [STATE_W-1:0] p, input logic u,
                                    input logic [3:0] rx, input logic [3:0] er);
      logic [4:0] window;
      logic [3:0] diff;
      window = {p, u};
      for (int g = 0; g < 4; g++) begin
         diff[g] = (^(window & GEN_TAPS[g])) ^ rx[g];
      end
      return $countones(diff & ~er);
   endfunction

   task automatic clear_block();
      for (int n = 0; n < NUM_STATES; n++) begin
         metric[n] = '0;
      end
      reachable  = 16'h0001;
      step_index = 0;
   endtask

   task automatic predict_step(input logic [3:0] rx, input logic [3:0] er, input logic last);
      logic [METRIC_W-1:0]   next_metric[NUM_STATES];
      logic [NUM_STATES-1:0] next_reach;
      logic [NUM_STATES-1:0] decision;
      logic [STATE_W-1:0]    p0, p1, st;
      logic                  bit_seq[MAX_STEPS];
      chunk_type             chunk;
      int                    m0, m1, best, steps, cnt, k, j;
      next_reach = '0;
      decision   = '0;
      for (int n = 0; n < NUM_STATES; n++) begin
         p0 = STATE_W'(n >> 1);
         p1 = p0 | 4'h8;
         m0 = metric[p0] + path_cost(p0, n[0], rx, er);
         m1 = metric[p1] + path_cost(p1, n[0], rx, er);
         best = 0;
         if (reachable[p0] && reachable[p1]) begin
            if (m1 < m0) begin
               best = m1;
               decision[n] = 1'b1;
            end else begin
               best = m0;
            end
         end else if (reachable[p0]) begin
            best = m0;
         end else if (reachable[p1]) begin
            best = m1;
            decision[n] = 1'b1;
         end
         if (best > int'(METRIC_MAX)) best = int'(METRIC_MAX);
         next_metric[n] = METRIC_W'(best);
         next_reach[n]  = reachable[p0] | reachable[p1];
      end
      metric = next_metric;
      reachable = next_reach;
      survivor[step_index] = decision;
      steps = step_index + 1;
      step_index = steps;
      if (last || steps == MAX_STEPS) begin
         // trace back from the all-zero state left by the tail
         st = '0;
         for (k = steps - 1; k >= 0; k--) begin
            bit_seq[k] = st[0];
            st = {survivor[k][st], st[3:1]};
         end
         for (k = 0; k < steps; k += 8) begin
            cnt = (steps - k > 8) ? 8 : steps - k;
            chunk.bits = '0;
            for (j = 0; j < cnt; j++) begin
               chunk.bits[7-j] = bit_seq[k+j];
            end
            chunk.count = CNT_W'(cnt);
            chunk.last  = (k + 8 >= steps);
            chunk_queue.push_back(chunk);
         end
         clear_block();
      end
   endtask

   task automatic check_chunk();
      chunk_type want;
      if (chunk_queue.size() == 0) begin
         $error("rsp transaction with no chunk expected: tdata %h tlast %b",
                rsp_tdata, rsp_tlast);
         mismatch_count++;
      end else begin
         want = chunk_queue.pop_front();
         chunks_checked++;
         if (rsp_tdata[7:0] !== want.bits) begin
            $error("decoded_byte: expected %h, actual %h", want.bits, rsp_tdata[7:0]);
            mismatch_count++;
         end
         if (rsp_tdata[11:8] !== want.count) begin
            $error("bit_count: expected %0d, actual %0d", want.count, rsp_tdata[11:8]);
            mismatch_count++;
         end
         if (rsp_tlast !== want.last) begin
            $error("last_chunk: expected %b, actual %b", want.last, rsp_tlast);
            mismatch_count++;
         end
         if (rsp_tdata[15:12] !== 4'h0) begin
            $error("tdata padding: expected 0, actual %h", rsp_tdata[15:12]);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_block();
         chunk_queue.delete();
      end else begin
         if (req_tvalid && req_tready) predict_step(req_tdata[3:0], req_tdata[7:4], req_tlast);
         if (rsp_tvalid && rsp_tready) check_chunk();
      end
      chunks_pending = chunk_queue.size();
   end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Viterbi decoder testbench
// Drives trellis steps into the decoder: a short directed set, one block that
// runs into the step limit, then random blocks that are mostly encoded data
// with noise and erasures, plus truncated and pure-noise blocks, under four
// mixes of sender idling and receiver stalling. The checker does the scoring.
// ----------------------------------------------------------------------------
module testbench;
   import vdk5_pkg::*;

   localparam int MAX_STEPS    = MAX_STEPS_DEF;
   localparam int RANDOM_STEPS = 350;

   typedef enum int {
      ERASE_NONE,
      ERASE_RANDOM,
      ERASE_PUNCTURE
   } erase_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [3:0] received_bits, [7:4] erased_mask
   logic        req_tlast  = 1'b0; // last_step
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [7:0] decoded_byte, [11:8] bit_count
   logic        rsp_tlast;         // last_chunk

   int mismatch_count, chunks_pending, chunks_checked;
   int send_idle  = 0;
   int recv_stall = 0;
   int steps_sent = 0;
   int blocks_sent = 0;
   int block_len = 0;

   viterbi_decoder_k5_erasures #(.MAX_STEPS(MAX_STEPS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   vdk5_decode_checker #(.MAX_STEPS(MAX_STEPS)) decode_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .chunks_pending (chunks_pending),
      .chunks_checked (chunks_checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_stall);
   end

   function automatic logic [3:0] encode(input logic [3:0] sr, input logic u);
      return {u ^ sr[0] ^ sr[2] ^ sr[3], u ^ sr[0] ^ sr[1] ^ sr[3],
              u ^ sr[1] ^ sr[2] ^ sr[3], u ^ sr[0] ^ sr[3]};
   endfunction

   // hold valid high across back-to-back transactions; drop it only for a gap
   task automatic send_step(input logic [3:0] rx, input logic [3:0] er, input logic last);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {er, rx};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      steps_sent++;
      block_len++;
      if (last || block_len == MAX_STEPS) begin
         blocks_sent++;
         block_len = 0;
      end
   endtask

   task automatic send_coded_block(input int data_len, input int flip_pct,
                                   input erase_mode_type erase_mode,
                                   input int steps_to_send, input logic tlast_at_end);
      logic [3:0] sr, flips, er;
      logic       u;
      int         i, b;
      sr = '0;
      for (i = 0; i < steps_to_send; i++) begin
         u = (i < data_len) ? 1'($urandom_range(1)) : 1'b0;
         flips = '0;
         er = '0;
         for (b = 0; b < 4; b++) begin
            flips[b] = ($urandom_range(99) < flip_pct);
         end
         case (erase_mode)
            ERASE_RANDOM: begin
               for (b = 0; b < 4; b++) er[b] = ($urandom_range(3) == 0);
            end
            ERASE_PUNCTURE: begin
               er = i[0] ? 4'b1100 : 4'b0101;
            end
            default: begin
               er = '0;
            end
         endcase
         send_step(encode(sr, u) ^ flips, er, tlast_at_end && (i == steps_to_send - 1));
         sr = {sr[2:0], u};
      end
   endtask

   task automatic send_noise_block(input int len);
      for (int i = 0; i < len; i++) begin
         send_step(4'($urandom), 4'($urandom), i == len - 1);
      end
   endtask

   initial begin
      int phase_start, pick, len, ph;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_step(4'hF, 4'h0, 1'b1);
      send_step(4'h0, 4'hF, 1'b1);
      send_coded_block(4, 0, ERASE_NONE, 8, 1'b1);
      send_noise_block(9);
      for (int i = 0; i < 5; i++) begin
         send_step(4'hF, 4'h0, i == 4);
      end

      // run one block into the step limit without tlast
      send_coded_block(MAX_STEPS - 4, 2, ERASE_RANDOM, MAX_STEPS, 1'b0);

      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 65; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 65; end
            default: begin send_idle = 30; recv_stall = 30; end
         endcase
         phase_start = steps_sent;
         while (steps_sent - phase_start < RANDOM_STEPS / 4) begin
            pick = $urandom_range(99);
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 60) : $urandom_range(1, 24);
            if (pick < 65) begin
               send_coded_block(len, $urandom_range(8),
                                erase_mode_type'($urandom_range(2)), len + 4, 1'b1);
            end else if (pick < 80) begin
               send_coded_block(len, $urandom_range(8),
                                erase_mode_type'($urandom_range(2)),
                                $urandom_range(1, len + 3), 1'b1);
            end else begin
               send_noise_block($urandom_range(1, 16));
            end
         end
      end

      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      @(negedge clock);
      while (chunks_pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);

      $display("covered %0d trellis steps in %0d blocks, one of them at the step limit",
               steps_sent, blocks_sent);
      $display("%0d chunks checked across four idle and stall mixes", chunks_checked);
      if (mismatch_count == 0 && chunks_pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: viterbi_decoder_k5_erasures.f
+incdir+design
design/vdk5_pkg.sv
design/vdk5_acs.sv
design/vdk5_traceback.sv
design/viterbi_decoder_k5_erasures.sv
design/vdk5_checker.sv
dv/vdk5_decode_checker.sv
dv/testbench.sv
